// ===== src/ihv_pkg.sv =====
// ----------------------------------------------------------------------------
// ihv_pkg
// Shared types and constants for the IPv4 header validator: word positions
// inside the header, verdict codes, the packet summary record and queue status.
// ----------------------------------------------------------------------------
package ihv_pkg;

  // Stream and counter widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CNT_W  = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  // Positions of the captured 16-bit header words
  localparam logic [CNT_W-1:0] IDX_VER_IHL   = 6'd0;
  localparam logic [CNT_W-1:0] IDX_TOTAL_LEN = 6'd1;
  localparam logic [CNT_W-1:0] IDX_IDENT     = 6'd2;
  localparam logic [CNT_W-1:0] IDX_FLAGS     = 6'd3;
  localparam logic [CNT_W-1:0] IDX_PROTO     = 6'd4;
  localparam logic [CNT_W-1:0] IDX_SRC_HI    = 6'd6;
  localparam logic [CNT_W-1:0] IDX_SRC_LO    = 6'd7;
  localparam logic [CNT_W-1:0] IDX_DST_HI    = 6'd8;
  localparam logic [CNT_W-1:0] IDX_DST_LO    = 6'd9;

  // Header checks
  localparam logic [4:0]  MIN_HDR_WORDS = 5'd10;   // 16-bit words of a minimal header
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  // Configuration register select (address bit 2)
  localparam logic REG_LOCAL_ADDR  = 1'b0;
  localparam logic REG_SUBNET_MASK = 1'b1;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    VERDICT_ICMP        = 4'd0,
    VERDICT_UDP         = 4'd1,
    VERDICT_SHORT       = 4'd2,
    VERDICT_VERSION     = 4'd3,
    VERDICT_HDRLEN      = 4'd4,
    VERDICT_FRAGMENT    = 4'd5,
    VERDICT_CHECKSUM    = 4'd6,
    VERDICT_OFF_NETWORK = 4'd7,
    VERDICT_PROTOCOL    = 4'd8
  } verdict_t;

  // Per-packet summary handed from front to back
  typedef struct packed {
    logic        short_pkt;
    logic        ver_ok;
    logic [3:0]  ihl;
    logic        more_frag;
    logic        csum_ok;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] total_len;
    logic [15:0] ident;
  } pkt_info_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// ===== src/ihv_front.sv =====
// ----------------------------------------------------------------------------
// ihv_front
// Word-rate front end: counts words, captures header fields, folds the
// ones'-complement header sum and emits a packet summary on the last word.
// ----------------------------------------------------------------------------
module ihv_front import ihv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              word_accept,
  input  logic [WORD_W-1:0] word,
  input  logic              last,
  output pkt_info_t         info,
  output logic              push
);

  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [15:0]       csum_r,  csum_nxt;
  logic [7:0]        vl_r,    vl_nxt;
  logic              mf_r,    mf_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [15:0]       len_r,   len_nxt;
  logic [15:0]       ident_r, ident_nxt;
  logic [31:0]       src_r,   src_nxt;
  logic [31:0]       dst_r,   dst_nxt;

  logic [4:0]  ihl2;
  logic [4:0]  need;
  logic [16:0] csum_sum;

  // Capture fields by word position, fold the header sum
  always_comb begin
    vl_nxt    = vl_r;
    mf_nxt    = mf_r;
    proto_nxt = proto_r;
    len_nxt   = len_r;
    ident_nxt = ident_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    case (cnt_r)
      IDX_VER_IHL:   vl_nxt = word[15:8];
      IDX_TOTAL_LEN: len_nxt = word;
      IDX_IDENT:     ident_nxt = word;
      IDX_FLAGS:     mf_nxt = word[13];
      IDX_PROTO:     proto_nxt = word[7:0];
      IDX_SRC_HI:    src_nxt = {word, src_r[15:0]};
      IDX_SRC_LO:    src_nxt = {src_r[31:16], word};
      IDX_DST_HI:    dst_nxt = {word, dst_r[15:0]};
      IDX_DST_LO:    dst_nxt = {dst_r[31:16], word};
      default: ;
    endcase

    ihl2     = {vl_nxt[3:0], 1'b0};
    csum_sum = {1'b0, csum_r} + {1'b0, word};
    if (cnt_r < {1'b0, ihl2}) begin
      csum_nxt = csum_sum[15:0] + {15'd0, csum_sum[16]};
    end else begin
      csum_nxt = csum_r;
    end

    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 6'd1;
    need    = (ihl2 > MIN_HDR_WORDS) ? ihl2 : MIN_HDR_WORDS;
  end

  // Summary of the packet as it stands after this word
  always_comb begin
    info.short_pkt = cnt_nxt < {1'b0, need};
    info.ver_ok    = vl_nxt[7:4] == IP_VERSION;
    info.ihl       = vl_nxt[3:0];
    info.more_frag = mf_nxt;
    info.csum_ok   = csum_nxt == CSUM_GOOD;
    info.proto     = proto_nxt;
    info.src       = src_nxt;
    info.dst       = dst_nxt;
    info.total_len = len_nxt;
    info.ident     = ident_nxt;
  end

  assign push = word_accept & last;

  // Advance on each item, clear at packet end
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r   <= '0;
      csum_r  <= '0;
      vl_r    <= '0;
      mf_r    <= 1'b0;
      proto_r <= '0;
      len_r   <= '0;
      ident_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (word_accept) begin
      cnt_r   <= cnt_nxt;
      csum_r  <= csum_nxt;
      vl_r    <= vl_nxt;
      mf_r    <= mf_nxt;
      proto_r <= proto_nxt;
      len_r   <= len_nxt;
      ident_r <= ident_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

endmodule

// ===== src/ihv_queue.sv =====
// ----------------------------------------------------------------------------
// ihv_queue
// Small FIFO of packet summaries that decouples the front end from the
// verdict stage.
// ----------------------------------------------------------------------------
module ihv_queue import ihv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pkt_info_t din,
  input  logic      pop,
  output pkt_info_t dout,
  output q_stat_t   stat
);

  pkt_info_t         q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= din;
    end
  end

  assign dout       = q_mem[rd_ptr_r];
  assign stat.full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign stat.count = count_r;

endmodule

// ===== src/ihv_back.sv =====
// ----------------------------------------------------------------------------
// ihv_back
// Verdict stage: ranks the header checks of one packet summary and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module ihv_back import ihv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pkt_info_t   info,
  input  logic        q_valid,
  output logic        q_pop,
  input  logic [31:0] local_addr,
  input  logic [31:0] subnet_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_verdict,
  output logic [7:0]  out_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_total_length,
  output logic [3:0]  out_header_words,
  output logic [15:0] out_ident
);

  verdict_t    verdict;
  logic        off_net;
  logic        valid_r;
  verdict_t    verdict_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] len_r;
  logic [3:0]  ihl_r;
  logic [15:0] ident_r;

  // Rank the checks, first failure wins
  always_comb begin
    off_net = ((info.src ^ local_addr) & subnet_mask) != 32'd0;
    if (info.short_pkt) begin
      verdict = VERDICT_SHORT;
    end else if (!info.ver_ok) begin
      verdict = VERDICT_VERSION;
    end else if (info.ihl < MIN_IHL) begin
      verdict = VERDICT_HDRLEN;
    end else if (info.more_frag) begin
      verdict = VERDICT_FRAGMENT;
    end else if (!info.csum_ok) begin
      verdict = VERDICT_CHECKSUM;
    end else if (off_net) begin
      verdict = VERDICT_OFF_NETWORK;
    end else if (info.proto == PROTO_ICMP) begin
      verdict = VERDICT_ICMP;
    end else if (info.proto == PROTO_UDP) begin
      verdict = VERDICT_UDP;
    end else begin
      verdict = VERDICT_PROTOCOL;
    end
  end

  // Load a new result when the output register is free or being drained
  assign q_pop = q_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      verdict_r <= verdict;
      proto_r   <= info.proto;
      src_r     <= info.src;
      dst_r     <= info.dst;
      len_r     <= info.total_len;
      ihl_r     <= info.ihl;
      ident_r   <= info.ident;
    end
  end

  assign out_valid          = valid_r;
  assign out_verdict        = verdict_r;
  assign out_protocol       = proto_r;
  assign out_source_address = src_r;
  assign out_dest_address   = dst_r;
  assign out_total_length   = len_r;
  assign out_header_words   = ihl_r;
  assign out_ident          = ident_r;

endmodule

// ===== src/ipv4_header_validator_core.sv =====
// A packet's summary enters the queue when its last word is accepted, then moves
// to the output register. The front end takes one 16-bit word per cycle while
// in_ready is high, and the output register gives one verdict per cycle while
// out_ready is high. Input stalls only when the two-entry summary queue is full.
// Reset (synchronous, rst_n low) clears the packet state, the queue, the
// output valid and both configuration registers.
// ----------------------------------------------------------------------------
// ipv4_header_validator_core
// IPv4 header validator: front end over the word stream, summary queue,
// verdict stage and the APB register file for address and netmask.
// ----------------------------------------------------------------------------
module ipv4_header_validator_core import ihv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Packet words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_packet_word,
  input  logic        in_last_word,
  // Verdicts
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_verdict,
  output logic [7:0]  out_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_total_length,
  output logic [3:0]  out_header_words,
  output logic [15:0] out_ident,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] local_addr_r;
  logic [31:0] subnet_mask_r;
  logic        cfg_write;
  logic        word_accept;
  logic        push;
  logic        q_pop;
  pkt_info_t   front_info;
  pkt_info_t   q_info;
  q_stat_t     q_stat;

  // Register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SUBNET_MASK) ? subnet_mask_r : local_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      subnet_mask_r <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SUBNET_MASK) begin
        subnet_mask_r <= pwdata;
      end else begin
        local_addr_r <= pwdata;
      end
    end
  end

  // Hold input while the summary queue has no room
  assign in_ready    = !q_stat.full;
  assign word_accept = in_valid && in_ready;

  ihv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .word_accept (word_accept),
    .word        (in_packet_word),
    .last        (in_last_word),
    .info        (front_info),
    .push        (push)
  );

  ihv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_info),
    .pop   (q_pop),
    .dout  (q_info),
    .stat  (q_stat)
  );

  ihv_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .info               (q_info),
    .q_valid            (!q_stat.empty),
    .q_pop              (q_pop),
    .local_addr         (local_addr_r),
    .subnet_mask        (subnet_mask_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_protocol       (out_protocol),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_total_length   (out_total_length),
    .out_header_words   (out_header_words),
    .out_ident          (out_ident)
  );

  // Queue occupancy never passes its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("summary queue overflow");

  // An accepted packet carries the matching protocol
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_ICMP) |-> out_protocol == PROTO_ICMP)
    else $error("icmp verdict with other protocol");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_UDP) |-> out_protocol == PROTO_UDP)
    else $error("udp verdict with other protocol");

  // An accepted packet has a header length of at least five 32-bit words
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == VERDICT_ICMP || out_verdict == VERDICT_UDP))
      |-> out_header_words >= MIN_IHL)
    else $error("accepted packet with short header length");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_header_validator_core. Streams IPv4 packets
// (clean, broken, truncated and pure noise) into the word channel, predicts
// the verdict record of every packet in a local model of the validator and
// compares each verdict that leaves the block, field by field, in order.
// The address and netmask registers are rewritten over the APB port between
// phases, and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ihv_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles without any handshake
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] total_len;
    logic [3:0]  hdr_words;
    logic [15:0] ident;
  } verdict_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_packet_word = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_verdict;
  logic [7:0]  out_protocol;
  logic [31:0] out_source_address;
  logic [31:0] out_dest_address;
  logic [15:0] out_total_length;
  logic [3:0]  out_header_words;
  logic [15:0] out_ident;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Validator model: configuration and per-packet state
  logic [31:0] net_local_addr = '0;
  logic [31:0] net_mask = '0;
  logic [5:0]  pw_count = '0;
  logic [15:0] hdr_sum = '0;
  logic [7:0]  hdr_ver_ihl = '0;
  logic [2:0]  hdr_flags = '0;
  logic [7:0]  hdr_proto = '0;
  logic [15:0] hdr_total_len = '0;
  logic [15:0] hdr_ident = '0;
  logic [31:0] hdr_src = '0;
  logic [31:0] hdr_dst = '0;

  verdict_rec_t expected_verdicts[$];
  logic [15:0]  pkt_words[$];

  int errors = 0;
  int words_sent = 0;
  int tx_gap_max = 0;
  int rx_stall_max = 0;
  int stall_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  ipv4_header_validator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_packet_word     (in_packet_word),
    .in_last_word       (in_last_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_protocol       (out_protocol),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_total_length   (out_total_length),
    .out_header_words   (out_header_words),
    .out_ident          (out_ident),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? s[15:0] + 16'd1 : s[15:0];
  endfunction

  // Advance the model by one word; return 1 with the verdict record on the last word
  function automatic bit predict_verdict(input logic [15:0] w, input logic last,
                                         output verdict_rec_t rec);
    int idx;
    int hdr_len;
    int need;
    verdict_t v;
    idx = pw_count;
    case (pw_count)
      IDX_VER_IHL:   hdr_ver_ihl    = w[15:8];
      IDX_TOTAL_LEN: hdr_total_len  = w;
      IDX_IDENT:     hdr_ident      = w;
      IDX_FLAGS:     hdr_flags      = w[15:13];
      IDX_PROTO:     hdr_proto      = w[7:0];
      IDX_SRC_HI:    hdr_src[31:16] = w;
      IDX_SRC_LO:    hdr_src[15:0]  = w;
      IDX_DST_HI:    hdr_dst[31:16] = w;
      IDX_DST_LO:    hdr_dst[15:0]  = w;
      default: ;
    endcase
    // sum only the words inside the declared header
    hdr_len = 2 * hdr_ver_ihl[3:0];
    if (idx < hdr_len) hdr_sum = ones_add(hdr_sum, w);
    if (pw_count != CNT_MAX) pw_count = pw_count + 6'd1;
    rec = '0;
    if (!last) return 1'b0;

    need = (hdr_len > int'(MIN_HDR_WORDS)) ? hdr_len : int'(MIN_HDR_WORDS);
    if (int'(pw_count) < need) v = VERDICT_SHORT;
    else if (hdr_ver_ihl[7:4] != IP_VERSION) v = VERDICT_VERSION;
    else if (hdr_ver_ihl[3:0] < MIN_IHL) v = VERDICT_HDRLEN;
    else if (hdr_flags[0]) v = VERDICT_FRAGMENT;
    else if (hdr_sum != CSUM_GOOD) v = VERDICT_CHECKSUM;
    else if (((hdr_src ^ net_local_addr) & net_mask) != 32'd0) v = VERDICT_OFF_NETWORK;
    else if (hdr_proto == PROTO_ICMP) v = VERDICT_ICMP;
    else if (hdr_proto == PROTO_UDP) v = VERDICT_UDP;
    else v = VERDICT_PROTOCOL;

    rec.verdict   = v;
    rec.proto     = hdr_proto;
    rec.src       = hdr_src;
    rec.dst       = hdr_dst;
    rec.total_len = hdr_total_len;
    rec.hdr_words = hdr_ver_ihl[3:0];
    rec.ident     = hdr_ident;

    // start over for the next packet
    pw_count      = '0;
    hdr_sum       = '0;
    hdr_ver_ihl   = '0;
    hdr_flags     = '0;
    hdr_proto     = '0;
    hdr_total_len = '0;
    hdr_ident     = '0;
    hdr_src       = '0;
    hdr_dst       = '0;
    return 1'b1;
  endfunction

  // Source address inside the configured subnet
  function automatic logic [31:0] local_src();
    logic [31:0] r;
    r = $urandom;
    return (net_local_addr & net_mask) | (r & ~net_mask);
  endfunction

  // Offer one item after a random gap; hold it until accepted
  task automatic send_word(input logic [15:0] w, input logic last);
    int gap;
    verdict_rec_t rec;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_packet_word <= w;
    in_last_word   <= last;
    do @(posedge clk); while (!in_ready);
    if (predict_verdict(w, last, rec)) expected_verdicts.push_back(rec);
    words_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_words[i]) send_word(pkt_words[i], i == pkt_words.size() - 1);
  endtask

  // Build a header (at least ten words) plus payload into pkt_words
  task automatic make_header(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [2:0] flags,
                             input logic [31:0] src, input bit good_csum,
                             input int payload_n);
    int n_hdr;
    logic [15:0] sum;
    logic [31:0] dst;
    logic [15:0] r;
    n_hdr = (2 * ihl > int'(MIN_HDR_WORDS)) ? 2 * ihl : int'(MIN_HDR_WORDS);
    dst = $urandom;
    r = 16'($urandom);
    pkt_words.delete();
    pkt_words.push_back({ver, ihl, r[7:0]});
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back({flags, r[12:0]});
    pkt_words.push_back({r[15:8], proto});
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(src[31:16]);
    pkt_words.push_back(src[15:0]);
    pkt_words.push_back(dst[31:16]);
    pkt_words.push_back(dst[15:0]);
    for (int i = 10; i < n_hdr; i++) pkt_words.push_back(16'($urandom));
    if (good_csum && ihl >= MIN_IHL) begin
      sum = '0;
      for (int i = 0; i < 2 * ihl; i++) if (i != 5) sum = ones_add(sum, pkt_words[i]);
      pkt_words[5] = ~sum;
    end
    repeat (payload_n) pkt_words.push_back(16'($urandom));
  endtask

  // Drop valid, wait out every verdict and the pipeline
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_SUBNET_MASK) net_mask = value;
    else net_local_addr = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t ns: register %0d readback: expected 0x%08h, actual 0x%08h",
               $time, sel, value, readback);
      errors++;
    end
  endtask

  task automatic set_network(input logic [31:0] addr, input logic [31:0] mask);
    settle();
    write_reg(REG_LOCAL_ADDR, addr);
    write_reg(REG_SUBNET_MASK, mask);
  endtask

  // Every verdict but off-network, and each field, under reset config (mask zero)
  task automatic test_verdicts_at_reset();
    tx_gap_max   = 7;
    rx_stall_max = 7;
    send_word({IP_VERSION, MIN_IHL, 8'h00}, 1'b1);
    make_header(IP_VERSION, MIN_IHL, PROTO_ICMP, 3'b000, $urandom, 1'b1, 0);
    void'(pkt_words.pop_back());
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_ICMP, 3'b010, $urandom, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, $urandom, 1'b1, 2);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, 8'd6, 3'b000, $urandom, 1'b1, 0);
    send_packet();
    make_header(4'd6, MIN_IHL, PROTO_UDP, 3'b000, $urandom, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, 4'd4, PROTO_UDP, 3'b000, $urandom, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b001, $urandom, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, $urandom, 1'b1, 0);
    pkt_words[5] = pkt_words[5] ^ 16'h0100;
    send_packet();
    // all-ones and all-zeros words
    pkt_words.delete();
    repeat (10) pkt_words.push_back(16'hFFFF);
    send_packet();
    pkt_words.delete();
    repeat (10) pkt_words.push_back(16'h0000);
    send_packet();
  endtask

  // Maximum header length, truncated long header, counter saturation
  task automatic test_long_packets();
    make_header(IP_VERSION, 4'd15, PROTO_UDP, 3'b000, $urandom, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, 4'd15, PROTO_ICMP, 3'b000, $urandom, 1'b1, 0);
    while (pkt_words.size() > 20) void'(pkt_words.pop_back());
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_ICMP, 3'b000, $urandom, 1'b1, 60);
    send_packet();
  endtask

  // Same-network test under a typical subnet and under a full mask
  task automatic test_subnet_check();
    set_network(32'hC0A8_0164, 32'hFFFF_FF00);
    make_header(IP_VERSION, MIN_IHL, PROTO_ICMP, 3'b000, 32'hC0A8_01FE, 1'b1, 0);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, 32'h0A00_0001, 1'b1, 0);
    send_packet();
    set_network(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, 32'hFFFF_FFFF, 1'b1, 1);
    send_packet();
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, 32'hFFFF_FFFE, 1'b1, 0);
    send_packet();
  endtask

  // Mostly clean packets, the rest broken, truncated or noise
  task automatic send_random_packet();
    int kind;
    int keep;
    logic [7:0] proto;
    logic [3:0] ihl;
    logic [2:0] flags;
    logic [31:0] src;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       proto = PROTO_ICMP;
      1:       proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    ihl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL;
    flags = 3'($urandom);
    flags[0] = ($urandom_range(0, 7) == 0);
    src = ($urandom_range(0, 5) == 0) ? 32'($urandom) : local_src();
    if (kind < 60) begin
      make_header(IP_VERSION, ihl, proto, flags, src, 1'b1, $urandom_range(0, 4));
    end else if (kind < 68) begin
      make_header(4'($urandom), ihl, proto, flags, src, 1'b1, $urandom_range(0, 2));
    end else if (kind < 74) begin
      make_header(IP_VERSION, 4'($urandom_range(0, 4)), proto, flags, src, 1'b1, 0);
    end else if (kind < 82) begin
      // flip one header bit
      make_header(IP_VERSION, ihl, proto, flags, src, 1'b1, $urandom_range(0, 2));
      keep = $urandom_range(0, 9);
      pkt_words[keep] = pkt_words[keep] ^ (16'h1 << $urandom_range(0, 15));
    end else if (kind < 90) begin
      make_header(IP_VERSION, ihl, proto, flags, src, 1'b1, 0);
      keep = $urandom_range(1, pkt_words.size() - 1);
      while (pkt_words.size() > keep) void'(pkt_words.pop_back());
    end else begin
      pkt_words.delete();
      repeat ($urandom_range(1, 12)) pkt_words.push_back(16'($urandom));
    end
    send_packet();
  endtask

  task automatic run_random_phase(input logic [31:0] addr, input logic [31:0] mask,
                                  input int gap_max, input int stall_max, input int n_words);
    int start;
    set_network(addr, mask);
    tx_gap_max   = gap_max;
    rx_stall_max = stall_max;
    start = words_sent;
    while (words_sent - start < n_words) send_random_packet();
  endtask

  task automatic test_random_traffic();
    int k;
    k = $urandom_range(0, 32);
    run_random_phase($urandom, 32'hFFFF_FF00, 7, 7, 45);
    run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 45);
    run_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 7, 0, 40);
    run_random_phase($urandom, (k == 0) ? 32'd0 : ~32'd0 << (32 - k), 0, 7, 45);
    run_random_phase(32'h0000_0000, 32'h0000_0000, 7, 7, 45);
  endtask

  // Hold the receiver off while short packets keep coming, so input stalls
  task automatic test_output_hold();
    settle();
    tx_gap_max   = 0;
    rx_stall_max = 3;
    hold_left    = HOLD_CYCLES;
    repeat (24) begin
      pkt_words.delete();
      repeat ($urandom_range(1, 2)) pkt_words.push_back(16'($urandom));
      send_packet();
    end
    make_header(IP_VERSION, MIN_IHL, PROTO_UDP, 3'b000, local_src(), 1'b1, 0);
    send_packet();
  endtask

  // Receiver: long hold, per-item stall, else ready
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each accepted verdict with the oldest prediction
  always @(posedge clk) begin
    verdict_rec_t exp_rec;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t ns: unexpected verdict: expected none, actual %0d",
                 $time, out_verdict);
        errors++;
      end else begin
        exp_rec = expected_verdicts.pop_front();
        check_field("verdict", exp_rec.verdict, out_verdict);
        check_field("protocol", exp_rec.proto, out_protocol);
        check_field("source_address", exp_rec.src, out_source_address);
        check_field("dest_address", exp_rec.dst, out_dest_address);
        check_field("total_length", exp_rec.total_len, out_total_length);
        check_field("header_words", exp_rec.hdr_words, out_header_words);
        check_field("ident", exp_rec.ident, out_ident);
      end
      stall_left = $urandom_range(0, rx_stall_max);
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** ipv4_header_validator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_verdicts_at_reset();
    test_long_packets();
    test_subnet_check();
    test_random_traffic();
    test_output_hold();

    // drain, then allow for any stray verdict
    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** ipv4_header_validator_core: PASSED **");
    end else begin
      $display("** ipv4_header_validator_core: FAILED **");
    end
    $finish;
  end

endmodule
